FILE: rtl/bitmap_multi_entry_allocator_macros.svh
// Assertion macros shared by the allocator checker.
`ifndef BITMAP_MULTI_ENTRY_ALLOCATOR_MACROS_SVH
`define BITMAP_MULTI_ENTRY_ALLOCATOR_MACROS_SVH

// Checks that a property holds at every clock edge outside reset.
`define BMEA_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that a condition never holds at a clock edge outside reset.
`define BMEA_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: rtl/bmea_pkg.sv
// Shared types, constants and helpers of the bitmap entry allocator.
package bmea_pkg;

	localparam int ENTRY_COUNT_DEF = 1024;
	localparam int MAX_REQUEST_DEF = 64;
	localparam int WORD_W          = 8;
	localparam int BIT_W           = 3;
	localparam int REQ_W           = 7;
	localparam int STAT_W          = 2;

	typedef enum logic [STAT_W-1:0] {
		STAT_GRANTED = 2'd0,
		STAT_INSUFF  = 2'd1,
		STAT_EMPTY   = 2'd2
	} status_t;

	typedef struct packed {
		logic    clr_step;
		logic    load_req;
		logic    rd;
		logic    ld_word;
		logic    claim;
		logic    wb;
		logic    emit_rej;
		status_t rej_status;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic req_zero;
		logic req_bad;
		logic word_full;
		logic last_claim;
		logic out_free;
	} sts_t;

	// Returns the index of the lowest clear bit of a map word.
	function automatic logic [BIT_W-1:0] first_zero(input logic [WORD_W-1:0] w);
		logic [BIT_W-1:0] idx;
		idx = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (!w[i]) begin
				idx = BIT_W'(i);
			end
		end
		return idx;
	endfunction

endpackage

FILE: rtl/bmea_ctrl.sv
// Controller state machine of the bitmap entry allocator.
module bmea_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  bmea_pkg::sts_t  sts,
	output bmea_pkg::cmd_t  cmd
);
	import bmea_pkg::*;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_DECIDE,
		S_READ,
		S_LOAD,
		S_CLAIM,
		S_DONE
	} state_t;

	state_t state_q;
	state_t state_d;

	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.rej_status = STAT_INSUFF;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.load_req = 1'b1;
					state_d      = S_DECIDE;
				end
			end
			S_DECIDE: begin
				priority if (sts.req_zero || sts.req_bad) begin
					cmd.rej_status = sts.req_zero ? STAT_EMPTY : STAT_INSUFF;
					if (sts.out_free) begin
						cmd.emit_rej = 1'b1;
						state_d      = S_IDLE;
					end
				end else begin
					cmd.rd  = 1'b1;
					state_d = S_LOAD;
				end
			end
			S_READ: begin
				cmd.rd  = 1'b1;
				state_d = S_LOAD;
			end
			S_LOAD: begin
				cmd.ld_word = 1'b1;
				state_d     = S_CLAIM;
			end
			S_CLAIM: begin
				priority if (sts.word_full) begin
					cmd.wb  = 1'b1;
					state_d = S_READ;
				end else if (sts.out_free) begin
					cmd.claim = 1'b1;
					if (sts.last_claim) begin
						state_d = S_DONE;
					end
				end else begin
					state_d = S_CLAIM;
				end
			end
			S_DONE: begin
				cmd.wb  = 1'b1;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: rtl/bmea_dp.sv
// Datapath of the bitmap entry allocator: map memory, counters and result register.
module bmea_dp #(
	parameter int ENTRY_COUNT = bmea_pkg::ENTRY_COUNT_DEF,
	parameter int MAX_REQUEST = bmea_pkg::MAX_REQUEST_DEF,
	parameter int NUM_W       = $clog2(ENTRY_COUNT + 1),
	parameter int DATA_W      = ((NUM_W + 7) / 8) * 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [bmea_pkg::REQ_W-1:0] req,
	input  bmea_pkg::cmd_t            cmd,
	output bmea_pkg::sts_t            sts,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [DATA_W-1:0]         m_tdata,
	output logic [bmea_pkg::STAT_W-1:0] m_tuser,
	output logic                      m_tlast
);
	import bmea_pkg::*;

	localparam int MAP_WORDS = (ENTRY_COUNT + WORD_W - 1) / WORD_W;
	localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int SUM_W     = AW + BIT_W + 1;
	localparam int CMP_W     = (NUM_W > REQ_W) ? NUM_W : REQ_W;
	localparam int PAD_BITS  = MAP_WORDS * WORD_W - ENTRY_COUNT;
	localparam logic [WORD_W-1:0] PAD_MASK = WORD_W'({WORD_W{1'b1}} << (WORD_W - PAD_BITS));
	localparam logic [AW-1:0] LAST_ADDR = AW'(MAP_WORDS - 1);

	logic [WORD_W-1:0] mem [MAP_WORDS];
	logic [WORD_W-1:0] rdata_q;
	logic [WORD_W-1:0] w_q;
	logic [AW-1:0]     addr_q;
	logic [NUM_W-1:0]  free_q;
	logic [REQ_W-1:0]  req_q;
	logic [REQ_W-1:0]  rem_q;
	logic              out_valid_q;
	logic [NUM_W-1:0]  out_num_q;
	status_t           out_st_q;
	logic              out_last_q;

	logic [WORD_W-1:0] eff_word;
	logic [BIT_W-1:0]  bit_idx;
	logic [SUM_W-1:0]  entry_sum;
	logic [AW-1:0]     addr_next;
	logic              word_is_full;
	logic              out_free;

	assign eff_word     = w_q | ((addr_q == LAST_ADDR) ? PAD_MASK : '0);
	assign word_is_full = &eff_word;
	assign bit_idx      = first_zero(eff_word);
	assign entry_sum    = SUM_W'({addr_q, bit_idx}) + SUM_W'(1);
	assign addr_next    = (addr_q == LAST_ADDR) ? '0 : addr_q + AW'(1);
	assign out_free     = !out_valid_q || m_tready;

	assign sts.clr_last   = (addr_q == LAST_ADDR);
	assign sts.req_zero   = (req_q == '0);
	assign sts.req_bad    = (req_q > REQ_W'(MAX_REQUEST)) ||
	                        (CMP_W'(req_q) > CMP_W'(free_q));
	assign sts.word_full  = word_is_full;
	assign sts.last_claim = (rem_q == REQ_W'(1));
	assign sts.out_free   = out_free;

	always_ff @(posedge clk) begin
		if (cmd.clr_step) begin
			mem[addr_q] <= '0;
		end else if (cmd.wb) begin
			mem[addr_q] <= w_q;
		end
		if (cmd.rd) begin
			rdata_q <= mem[addr_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_q <= req;
		end
		if (cmd.ld_word) begin
			w_q <= rdata_q;
		end else if (cmd.claim) begin
			w_q <= w_q | (WORD_W'(1) << bit_idx);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
			free_q <= NUM_W'(ENTRY_COUNT);
			rem_q  <= '0;
		end else begin
			if (cmd.clr_step || (cmd.wb && word_is_full)) begin
				addr_q <= addr_next;
			end
			if (cmd.load_req) begin
				rem_q <= req;
			end else if (cmd.claim) begin
				rem_q <= rem_q - REQ_W'(1);
			end
			if (cmd.claim) begin
				free_q <= free_q - NUM_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.claim || cmd.emit_rej) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.claim) begin
			out_num_q  <= entry_sum[NUM_W-1:0];
			out_st_q   <= STAT_GRANTED;
			out_last_q <= sts.last_claim;
		end else if (cmd.emit_rej) begin
			out_num_q  <= '0;
			out_st_q   <= cmd.rej_status;
			out_last_q <= 1'b1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = DATA_W'(out_num_q);
	assign m_tuser  = out_st_q;
	assign m_tlast  = out_last_q;

endmodule

FILE: rtl/bitmap_multi_entry_allocator.sv
// Top level of the bitmap first-fit multi-entry allocator.
//
// Channel  Direction  Payload
// s_*      in         tdata: request_count
// m_*      out        tdata: entry_number; tuser: status; tlast: last
//
// After reset the map is swept clear with s_tready low, one word per cycle.
// A rejected or empty request gives its result from S_DECIDE once the result register is
// free, and the controller then returns to S_IDLE to accept the next request.
// A granted request reads, loads and claims map words in turn (S_READ, S_LOAD, S_CLAIM),
// one result per claim, and frees the input after S_DONE writes the last word back.
// A stalled m_tready holds the result register and pauses the claim loop.
module bitmap_multi_entry_allocator #(
	parameter int ENTRY_COUNT = bmea_pkg::ENTRY_COUNT_DEF,
	parameter int MAX_REQUEST = bmea_pkg::MAX_REQUEST_DEF,
	parameter int NUM_W       = $clog2(ENTRY_COUNT + 1),
	parameter int DATA_W      = ((NUM_W + 7) / 8) * 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [7:0]                  s_tdata,   // [6:0] request_count
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [DATA_W-1:0]           m_tdata,   // [NUM_W-1:0] entry_number
	output logic [bmea_pkg::STAT_W-1:0] m_tuser,   // [1:0] status
	output logic                        m_tlast
);
	import bmea_pkg::*;

	cmd_t cmd;
	sts_t sts;

	bmea_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	bmea_dp #(
		.ENTRY_COUNT (ENTRY_COUNT),
		.MAX_REQUEST (MAX_REQUEST),
		.NUM_W       (NUM_W),
		.DATA_W      (DATA_W)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (s_tdata[REQ_W-1:0]),
		.cmd      (cmd),
		.sts      (sts),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

FILE: rtl/bmea_chk.sv
// Port-level checker of the bitmap entry allocator and its bind.
`include "bitmap_multi_entry_allocator_macros.svh"

module bmea_chk #(
	parameter int ENTRY_COUNT = bmea_pkg::ENTRY_COUNT_DEF,
	parameter int NUM_W       = $clog2(ENTRY_COUNT + 1),
	parameter int DATA_W      = ((NUM_W + 7) / 8) * 8
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_tvalid,
	input logic                        s_tready,
	input logic                        m_tvalid,
	input logic                        m_tready,
	input logic [DATA_W-1:0]           m_tdata,
	input logic [bmea_pkg::STAT_W-1:0] m_tuser,
	input logic                        m_tlast
);
	import bmea_pkg::*;

	logic [DATA_W-1:0] prev_num_q;
	logic              granted;

	assign granted = (m_tuser == STAT_GRANTED);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_num_q <= '0;
		end else begin
			if (m_tvalid && m_tready && granted) begin
				prev_num_q <= m_tdata;
			end
		end
	end

	`BMEA_ASSERT(a_reject_is_last, clk, arst_n, (m_tvalid && !granted) |-> (m_tlast && m_tdata == '0), "Rejected request result is not a single zero entry.")
	`BMEA_ASSERT(a_grant_rises, clk, arst_n, (m_tvalid && granted) |-> (m_tdata > prev_num_q && m_tdata <= DATA_W'(ENTRY_COUNT)), "Granted entry number out of order or range.")
	`BMEA_ASSERT_NEVER(a_no_overlap, clk, arst_n, s_tready && m_tvalid && !m_tlast, "Input ready while a non-final result is pending.")
	`BMEA_ASSERT(a_hold_stall, clk, arst_n, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)), "Stalled result changed.")

endmodule

bind bitmap_multi_entry_allocator bmea_chk #(
	.ENTRY_COUNT (ENTRY_COUNT),
	.NUM_W       (NUM_W),
	.DATA_W      (DATA_W)
) u_bmea_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
